// File: design/swm_pkg.sv
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int SAMPLE_W        = 32;
  localparam int OUT_W           = 33;
  localparam int CFG_W           = 7;
  localparam int DATA_W          = 32;
  localparam int APB_ADDR_W      = 2;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_APPEND,
    S_PICK,
    S_EMIT
  } swm_state_t;

  typedef struct packed {
    logic accept;
    logic remove;
    logic insert;
    logic append;
    logic pick;
    logic emit;
    logic finish;
  } swm_cmd_t;

  typedef struct packed {
    logic full;
    logic reaches_full;
    logic out_busy;
  } swm_status_t;

  function automatic int eff_window(input logic [CFG_W-1:0] v, input int wmax);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > wmax) r = wmax;
    return r;
  endfunction

endpackage

// File: design/sliding_window_median.sv
// each input is accepted only in idle and worked through before another is taken:
// with a full window by the remove, insert and pick steps, while it fills by an append
// step alone, and for the item that fills it by append and pick; median_x2 and
// out_valid are then registered in the emit step, which waits while a result is still
// unread; the steps use the sorted cell row and the registered read of the arrival ring
// reset (rst, synchronous): window emptied, window_size back to 5, no result pending
module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [swm_pkg::DATA_W-1:0]          pwdata,
  output logic [swm_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_sample,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic signed [swm_pkg::OUT_W-1:0]    median_x2,
  output logic                                out_valid,
  input  logic                                out_ready
);
  import swm_pkg::*;

  swm_cmd_t    cmd;
  swm_status_t status;
  logic        addr_unused;

  // single register, every address decodes to it
  assign addr_unused = ^paddr;
  assign pready      = 1'b1 | addr_unused;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .sample      (sample),
    .last_sample (last_sample),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .median_x2   (median_x2)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result written over a waiting result");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in work");

  a_remove_then_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |=> cmd.insert)
    else $error("removal not followed by insertion");

  a_insert_then_pick: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> cmd.pick)
    else $error("full window update not followed by median pick");

endmodule

// File: design/swm_ram.sv
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/swm_ctrl.sv
module swm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t    cmd
);
  import swm_pkg::*;

  swm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.full ? S_REMOVE : S_APPEND;
        end
      end
      S_REMOVE: state_next = S_INSERT;
      S_INSERT: state_next = S_PICK;
      S_APPEND: state_next = status.reaches_full ? S_PICK : S_IDLE;
      S_PICK:   state_next = S_EMIT;
      S_EMIT: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_REMOVE: cmd.remove = 1'b1;
      S_INSERT: cmd.insert = 1'b1;
      S_APPEND: begin
        cmd.append = 1'b1;
        cmd.finish = !status.reaches_full;
      end
      S_PICK:   cmd.pick = 1'b1;
      S_EMIT: begin
        cmd.emit   = !status.out_busy;
        cmd.finish = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: design/swm_datapath.sv
module swm_datapath #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swm_pkg::DATA_W-1:0]          pwdata,
  output logic [swm_pkg::DATA_W-1:0]          prdata,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_sample,
  input  swm_pkg::swm_cmd_t                   cmd,
  output swm_pkg::swm_status_t                status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [swm_pkg::OUT_W-1:0]    median_x2
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int SB = SAMPLE_BITS;

  logic [CFG_W-1:0] window_size;
  logic [KW-1:0]    k;
  logic [KW-1:0]    fill, fill_next, fill_norm;
  logic [AW-1:0]    oldest, oldest_next, oldest_norm, oldest_wrap;
  logic [KW-1:0]    oldest_inc;
  logic [KW:0]      pos_sum, pos_wrap;
  logic             cfg_wr;
  logic             last_q;
  logic signed [SB-1:0] sample_q;
  logic signed [SB-1:0] old_val;
  logic signed [SB-1:0] cells [WINDOW_MAX];
  logic signed [SB-1:0] cells_next [WINDOW_MAX];
  logic signed [SB-1:0] up [WINDOW_MAX];
  logic signed [SB-1:0] dn [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] gt, gt_prev;
  logic signed [SB-1:0] mid_lo, mid_hi;
  logic signed [SB:0]   mid_sum;
  logic [AW-1:0]        hi_idx, lo_idx;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;

  // config register
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = DATA_W'(window_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
      k           <= KW'(eff_window(WINDOW_SIZE_RST, WINDOW_MAX));
    end else if (cfg_wr) begin
      window_size <= pwdata[CFG_W-1:0];
      k           <= KW'(eff_window(pwdata[CFG_W-1:0], WINDOW_MAX));
    end
  end

  // window bookkeeping
  always_comb begin
    fill_norm   = (fill > k) ? '0 : fill;
    oldest_norm = ((fill > k) || (KW'(oldest) >= k)) ? '0 : oldest;
    oldest_inc  = KW'(oldest) + KW'(1);
    oldest_wrap = (oldest_inc >= k) ? '0 : AW'(oldest_inc);
    pos_sum     = (KW + 1)'(oldest) + (KW + 1)'(fill);
    pos_wrap    = (pos_sum >= (KW + 1)'(k)) ? pos_sum - (KW + 1)'(k) : pos_sum;
  end

  assign status.full         = (fill_norm == k);
  assign status.reaches_full = ((KW + 1)'(fill) + (KW + 1)'(1)) == (KW + 1)'(k);
  assign status.out_busy     = out_valid & ~out_ready;

  always_comb begin
    fill_next   = fill;
    oldest_next = oldest;
    if (cmd.accept) begin
      fill_next   = fill_norm;
      oldest_next = oldest_norm;
    end
    if (cmd.remove) begin
      fill_next   = k - KW'(1);
      oldest_next = oldest_wrap;
    end
    if (cmd.insert || cmd.append) begin
      fill_next = fill + KW'(1);
    end
    if (cmd.finish && last_q) begin
      fill_next   = '0;
      oldest_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      fill   <= '0;
      oldest <= '0;
    end else begin
      fill   <= fill_next;
      oldest <= oldest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample[SB-1:0];
      last_q   <= last_sample;
    end
  end

  // arrival order ring
  assign ram_we    = cmd.remove | cmd.append;
  assign ram_waddr = cmd.remove ? oldest : AW'(pos_wrap);

  swm_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample_q),
    .raddr (oldest_norm),
    .rdata (old_val)
  );

  // sorted cell row, each cell looks at its neighbors only
  always_comb begin
    gt_prev[0]            = 1'b0;
    dn[0]                 = cells[0];
    up[WINDOW_MAX-1]      = cells[WINDOW_MAX-1];
    for (int i = 0; i < WINDOW_MAX; i++) begin
      gt[i] = (i >= int'(fill)) || (cells[i] > sample_q);
    end
    for (int i = 1; i < WINDOW_MAX; i++) begin
      gt_prev[i] = gt[i-1];
      dn[i]      = cells[i-1];
      up[i-1]    = cells[i];
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cells_next[i] = cells[i];
      if (cmd.remove) begin
        if (cells[i] >= old_val) begin
          cells_next[i] = up[i];
        end
      end else if (cmd.insert || cmd.append) begin
        if (gt[i]) begin
          cells_next[i] = gt_prev[i] ? dn[i] : sample_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // middle pick and result register
  assign hi_idx = AW'(k >> 1);
  assign lo_idx = k[0] ? hi_idx : hi_idx - AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      mid_lo <= cells[lo_idx];
      mid_hi <= cells[hi_idx];
    end
  end

  assign mid_sum = (SB + 1)'(mid_lo) + (SB + 1)'(mid_hi);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      median_x2 <= OUT_W'(mid_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: dv/sliding_window_median_tb.sv
module sliding_window_median_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [swm_pkg::APB_ADDR_W-1:0] WINDOW_SIZE_ADDR = '0;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [31:0] value;
    logic        ends_seq;
  } in_item_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [swm_pkg::APB_ADDR_W-1:0]      paddr = '0;
  logic [swm_pkg::DATA_W-1:0]          pwdata = '0;
  logic [swm_pkg::DATA_W-1:0]          prdata;
  logic                                pready;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                last_sample = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [swm_pkg::OUT_W-1:0]    median_x2;
  logic                                out_valid;
  logic                                out_ready = 1'b0;

  in_item_t          pending_samples[$];
  logic [32:0]       medians_due[$];
  logic signed [31:0] ring_q [WMAX];
  logic signed [31:0] sorted_q [WMAX];
  int                fill_n = 0;
  int                oldest_idx = 0;
  logic [6:0]        win_reg = swm_pkg::WINDOW_SIZE_RST;

  bit calm = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  int cycle_count = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int medians_seen = 0;
  int seq_ends = 0;
  int settings_used = 0;
  int mismatches = 0;

  sliding_window_median i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample(sample), .last_sample(last_sample), .in_valid(in_valid), .in_ready(in_ready),
    .median_x2(median_x2), .out_valid(out_valid), .out_ready(out_ready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int clamp_window(input logic [6:0] v);
    int k;
    k = int'(v);
    if (k < 1) k = 1;
    if (k > WMAX) k = WMAX;
    return k;
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 32'(int'($urandom_range(0, 16)) - 8);
      4: begin
        case ($urandom_range(0, 3))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      5: v = $urandom_range(0, 1) ? S_MIN + $urandom_range(0, 3) : S_MAX - $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic place_sorted(input int n, input logic signed [31:0] v);
    int i;
    i = n;
    while (i > 0 && sorted_q[i-1] > v) begin
      sorted_q[i] = sorted_q[i-1];
      i--;
    end
    sorted_q[i] = v;
  endtask

  task automatic advance_window(input logic signed [31:0] s, input logic ends_seq);
    int k;
    int i;
    int h;
    logic signed [31:0] old;
    logic [32:0] m;
    k = clamp_window(win_reg);
    if (fill_n > k) begin
      fill_n = 0;
      oldest_idx = 0;
    end
    if (oldest_idx >= k) oldest_idx = 0;
    if (fill_n < k) begin
      ring_q[(oldest_idx + fill_n) % k] = s;
      place_sorted(fill_n, s);
      fill_n++;
    end else begin
      old = ring_q[oldest_idx];
      i = 0;
      while (i < k && sorted_q[i] != old) i++;
      for (; i + 1 < k; i++) sorted_q[i] = sorted_q[i+1];
      place_sorted(k - 1, s);
      ring_q[oldest_idx] = s;
      oldest_idx++;
      if (oldest_idx >= k) oldest_idx = 0;
    end
    if (fill_n == k) begin
      h = k / 2;
      if (k % 2) m = {sorted_q[h][31], sorted_q[h]} + {sorted_q[h][31], sorted_q[h]};
      else m = {sorted_q[h-1][31], sorted_q[h-1]} + {sorted_q[h][31], sorted_q[h]};
      medians_due.push_back(m);
    end
    if (ends_seq) begin
      fill_n = 0;
      oldest_idx = 0;
    end
  endtask

  task automatic flag_mismatch(input bit had_due, input logic [32:0] want, input logic [32:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      if (had_due) $display("median_x2 mismatch: expected %0d, got %0d", $signed(want), $signed(got));
      else $display("median_x2 %0d arrived with nothing expected", $signed(got));
    end
  endtask

  task automatic queue_sample(input logic [31:0] v, input logic ends_seq);
    in_item_t it;
    it.value = v;
    it.ends_seq = ends_seq;
    pending_samples.push_back(it);
    items_queued++;
  endtask

  task automatic write_window(input logic [6:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_SIZE_ADDR;
    pwdata <= {25'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_reg = v;
    fill_n = 0;
    oldest_idx = 0;
    settings_used++;
  endtask

  task automatic drain_block();
    while (items_accepted != items_queued || medians_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        sample <= pending_samples[0].value;
        last_sample <= pending_samples[0].ends_seq;
        void'(pending_samples.pop_front());
        if (!calm && $urandom_range(0, 11) == 0) in_gap <= $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) out_stall <= $urandom_range(1, 18);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        advance_window(sample, last_sample);
        items_accepted++;
        if (last_sample) seq_ends++;
      end
      if (out_valid && out_ready) begin
        medians_seen++;
        if (medians_due.size() == 0) flag_mismatch(1'b0, '0, median_x2);
        else begin
          if (median_x2 !== medians_due[0]) flag_mismatch(1'b1, medians_due[0], median_x2);
          void'(medians_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int win_list[$];
    int phase_no;
    int k;
    int budget;
    int n_phase;
    int len;
    bit ends;
    logic [6:0] wv;
    int failures;
    win_list = '{1, 0, 127, 64, 2, 3, 4, 8, 63, 17, 6, 32};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset window of 5: short sequence, then extremes
    @(negedge clk);
    queue_sample(32'd5, 1'b0);
    queue_sample(-32'sd5, 1'b0);
    queue_sample(32'd7, 1'b1);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample('1, 1'b0);
    queue_sample(32'd1, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b1);
    drain_block();
    write_window(7'd4);
    @(negedge clk);
    for (int j = 0; j < 4; j++) queue_sample(S_MAX, j == 3);
    for (int j = 0; j < 4; j++) queue_sample(S_MIN, j == 3);

    phase_no = 0;
    while (items_queued < 1430) begin
      if (items_queued > 1250) calm <= 1'b1;
      if (phase_no < win_list.size()) wv = 7'(win_list[phase_no]);
      else wv = (phase_no % 2) ? 7'($urandom_range(1, 20)) : 7'($urandom_range(0, 127));
      phase_no++;
      drain_block();
      write_window(wv);
      k = clamp_window(wv);
      budget = (k > 30) ? 3 * k : 90;
      n_phase = 0;
      @(negedge clk);
      while (n_phase < budget && items_queued < 1430) begin
        // mostly sequences that fill the window, some that end early
        if ($urandom_range(0, 9) < 2) len = $urandom_range(1, k);
        else len = k + $urandom_range(0, 2 * k + 4);
        ends = ($urandom_range(0, 9) != 0);
        for (int j = 0; j < len; j++)
          queue_sample(pick_sample(), (j == len - 1) ? ends : ($urandom_range(0, 99) == 0));
        n_phase += len;
      end
    end

    drain_block();
    failures = mismatches + medians_due.size();
    $display("%0d samples in %0d ended sequences under %0d window writes, %0d medians compared",
             items_accepted, seq_ends, settings_used, medians_seen);
    $display("%0d mismatches, %0d medians never seen", mismatches, medians_due.size());
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sliding_window_median.f
design/swm_pkg.sv
design/swm_ram.sv
design/swm_ctrl.sv
design/swm_datapath.sv
design/sliding_window_median.sv
dv/sliding_window_median_tb.sv
